// ===== design/gctb_pkg.sv =====
// ----------------------------------------------------------------------------
// Traversability map package
// Grid geometry, register indexes, cell classes and fixed-point constants
// shared by the traversability filter and its channel interfaces.
// ----------------------------------------------------------------------------
package gctb_pkg;

    // Grid geometry: one entry per cell, row-major.
    localparam int GRID_SIZE = 16;
    localparam int CELLS     = GRID_SIZE * GRID_SIZE;
    localparam int IDX_W     = $clog2(CELLS);

    // Field widths fixed by the channel payloads.
    localparam int COORD_W = 4;
    localparam int SLOPE_W = 16;
    localparam int COUNT_W = 16;
    localparam int PROB_W  = 16;
    localparam int LIMIT_W = 15;
    localparam int CFG_W   = 16;

    // Q0.16 constants: 1.0 needs one extra bit.
    localparam logic [PROB_W:0]   ONE_Q16   = 17'd65536;
    localparam logic [PROB_W-1:0] PROB_HALF = 16'd32768;
    localparam logic [PROB_W-1:0] PROB_MAX  = 16'd65535;

    // Register reset values.
    localparam logic [LIMIT_W-1:0] SLOPE_LIMIT_RST  = 15'd2048;
    localparam logic [PROB_W-1:0]  SENSOR_TRUST_RST = 16'd52429;
    localparam logic [PROB_W-1:0]  STAY_PROB_RST    = 16'd52429;
    localparam logic [COUNT_W-1:0] MIN_POINTS_RST   = 16'd1000;

    // Request kinds.
    localparam logic REQ_UPDATE = 1'b0;
    localparam logic REQ_READ   = 1'b1;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_SLOPE_LIMIT  = 2'd0,
        CFG_SENSOR_TRUST = 2'd1,
        CFG_STAY_PROB    = 2'd2,
        CFG_MIN_POINTS   = 2'd3
    } t_cfg_idx;

    // Cell classes.
    typedef enum logic [1:0] {
        CLS_UNOBS = 2'd0,
        CLS_TRAV  = 2'd1,
        CLS_STEEP = 2'd2
    } t_cell_class;

    // One stored cell: class and traversable probability.
    typedef struct packed {
        t_cell_class           cls;
        logic [PROB_W-1:0]     prob;
    } t_entry;

endpackage

// ===== design/gctb_req_if.sv =====
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one update or read word per handshake.
// ----------------------------------------------------------------------------
interface gctb_req_if;
    import gctb_pkg::*;

    logic                       valid;
    logic                       ready;
    logic                       req_type;
    logic [COORD_W-1:0]         cell_row;
    logic [COORD_W-1:0]         cell_col;
    logic signed [SLOPE_W-1:0]  slope_x;
    logic signed [SLOPE_W-1:0]  slope_y;
    logic [COUNT_W-1:0]         point_count;

    modport source (
        output valid, req_type, cell_row, cell_col, slope_x, slope_y, point_count,
        input  ready
    );

    modport sink (
        input  valid, req_type, cell_row, cell_col, slope_x, slope_y, point_count,
        output ready
    );

endinterface

// ===== design/gctb_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one cell report word per handshake.
// ----------------------------------------------------------------------------
interface gctb_rsp_if;
    import gctb_pkg::*;

    logic               valid;
    logic               ready;
    logic [1:0]         cell_class;
    logic [PROB_W-1:0]  trav_prob;
    logic               updated;

    modport source (
        output valid, cell_class, trav_prob, updated,
        input  ready
    );

    modport sink (
        input  valid, cell_class, trav_prob, updated,
        output ready
    );

endinterface

// ===== design/gctb_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gctb_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 256
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [$clog2(DEPTH)-1:0]     i_waddr,
    input  logic [WIDTH-1:0]             i_wdata,
    input  logic [$clog2(DEPTH)-1:0]     i_raddr,
    output logic [WIDTH-1:0]             o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/grid_cell_traversability_bayes_top.sv =====
// ----------------------------------------------------------------------------
// Traversability map with a binary Bayes filter per cell
// Keeps probability and class for every grid cell and updates them from
// slope observations with one shared multiply-accumulate unit and a
// bit-serial restoring divider.
// ----------------------------------------------------------------------------
// Sequence: a read word, or an update with too few points, passes from
// acceptance through the RAM read (S_RD, S_LOAD) to a loaded result; a full
// update adds eight MAC passes, setup, 17 divider steps and write-back.
// Throughput: one word at a time; a new word is taken only after the last
// result is loaded into a free result register. Synchronous active-low reset clears
// all cells to 0.5 / unobserved at once through per-cell valid bits.
// ----------------------------------------------------------------------------
module grid_cell_traversability_bayes_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    gctb_req_if.sink             i_req,
    gctb_rsp_if.source           o_rsp,
    input  logic                 i_cfg_we,
    input  gctb_pkg::t_cfg_idx   i_cfg_idx,
    input  logic [gctb_pkg::CFG_W-1:0] i_cfg_data
);
    import gctb_pkg::*;

    localparam int ACC_W = 49;   // p and q reach 2^48
    localparam int PR_W  = 33;   // priors reach 2^32
    localparam int SUM_W = 34;
    localparam int REM_W = 35;
    localparam int QUO_W = 17;
    localparam int NUM_W = 50;
    localparam logic [4:0] DIV_LAST_BIT = 5'(QUO_W - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_LOAD,
        S_MAC,
        S_SETUP,
        S_DIV,
        S_WB,
        S_OUT
    } t_state;

    // Configuration registers.
    logic [LIMIT_W-1:0] r_slope_limit;
    logic [PROB_W-1:0]  r_trust;
    logic [PROB_W-1:0]  r_stay;
    logic [COUNT_W-1:0] r_min_pts;

    // Sequencer and captured request.
    t_state                    r_state;
    logic                      r_req_type;
    logic [IDX_W-1:0]          r_idx;
    logic signed [SLOPE_W-1:0] r_sx;
    logic signed [SLOPE_W-1:0] r_sy;
    logic [COUNT_W-1:0]        r_cnt;

    // Cell contents and valid bits.
    logic [CELLS-1:0]   r_vld;
    logic [PROB_W-1:0]  r_prob;
    t_cell_class        r_cls;
    logic               r_flat;
    logic               r_upd;
    t_entry             ram_rd;
    t_entry             ram_wr;
    logic               ram_we;
    logic [PROB_W-1:0]  new_prob;

    // Shared MAC.
    logic [2:0]         r_step;
    logic [ACC_W-1:0]   r_acc;
    logic [PR_W-1:0]    r_prt;
    logic [PR_W-1:0]    r_prn;
    logic [ACC_W-1:0]   r_p;
    logic [PROB_W:0]    mac_a;
    logic [PROB_W:0]    mac_b;
    logic               mac_clr;
    logic               mac_shift;
    logic [2*PROB_W+1:0] mac_prod;
    logic [ACC_W-1:0]   mac_add;
    logic [ACC_W-1:0]   mac_sum;

    // Divider.
    logic [SUM_W-1:0]   r_sum;
    logic [REM_W-1:0]   r_rem;
    logic [QUO_W-1:0]   r_num_lo;
    logic [QUO_W-1:0]   r_quo;
    logic [4:0]         r_bit;
    t_cell_class        r_new_cls;
    logic [PR_W-1:0]    ps;
    logic [PR_W-1:0]    qs;
    logic [SUM_W-1:0]   sum;
    logic [NUM_W-1:0]   num;
    logic [REM_W-1:0]   trial;
    logic               trial_ge;

    // Result register.
    logic               r_out_valid;
    t_cell_class        r_out_cls;
    logic [PROB_W-1:0]  r_out_prob;
    logic               r_out_upd;
    logic               out_load;

    // Slope test on magnitudes.
    logic [SLOPE_W-1:0] mag_x;
    logic [SLOPE_W-1:0] mag_y;
    logic [PROB_W:0]    p_cmp;
    logic [PROB_W:0]    s_ext;
    logic [PROB_W:0]    s_cmp;
    logic [PROB_W:0]    t_ext;
    logic [PROB_W:0]    t_cmp;
    logic [PROB_W:0]    a_p;
    logic [PROB_W:0]    a_q;
    logic               do_update;

    // Cell storage.
    gctb_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (CELLS)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata (ram_wr),
        .i_raddr (r_idx),
        .o_rdata (ram_rd)
    );

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slope_limit <= SLOPE_LIMIT_RST;
            r_trust       <= SENSOR_TRUST_RST;
            r_stay        <= STAY_PROB_RST;
            r_min_pts     <= MIN_POINTS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SLOPE_LIMIT:  r_slope_limit <= i_cfg_data[LIMIT_W-1:0];
                CFG_SENSOR_TRUST: r_trust       <= i_cfg_data;
                CFG_STAY_PROB:    r_stay        <= i_cfg_data;
                CFG_MIN_POINTS:   r_min_pts     <= i_cfg_data;
            endcase
        end
    end

    // Observation and update decision from the captured word.
    assign mag_x     = r_sx[SLOPE_W-1] ? SLOPE_W'(-r_sx) : SLOPE_W'(r_sx);
    assign mag_y     = r_sy[SLOPE_W-1] ? SLOPE_W'(-r_sy) : SLOPE_W'(r_sy);
    assign do_update = (r_req_type == REQ_UPDATE) && (r_cnt >= r_min_pts);

    // Probability complements; 1.0 needs 17 bits.
    assign p_cmp = ONE_Q16 - {1'b0, r_prob};
    assign s_ext = {1'b0, r_stay};
    assign s_cmp = ONE_Q16 - s_ext;
    assign t_ext = {1'b0, r_trust};
    assign t_cmp = ONE_Q16 - t_ext;
    assign a_p   = r_flat ? t_ext : t_cmp;
    assign a_q   = r_flat ? t_cmp : t_ext;

    // Operand schedule of the shared MAC: the two priors, then p and q
    // as products of a 17-bit likelihood with a 33-bit prior in two halves.
    always_comb begin
        unique case (r_step)
            3'd0: begin mac_a = s_ext; mac_b = {1'b0, r_prob};       mac_clr = 1'b1; mac_shift = 1'b0; end
            3'd1: begin mac_a = s_cmp; mac_b = p_cmp;                mac_clr = 1'b0; mac_shift = 1'b0; end
            3'd2: begin mac_a = s_cmp; mac_b = {1'b0, r_prob};       mac_clr = 1'b1; mac_shift = 1'b0; end
            3'd3: begin mac_a = s_ext; mac_b = p_cmp;                mac_clr = 1'b0; mac_shift = 1'b0; end
            3'd4: begin mac_a = a_p;   mac_b = {1'b0, r_prt[15:0]};  mac_clr = 1'b1; mac_shift = 1'b0; end
            3'd5: begin mac_a = a_p;   mac_b = r_prt[PR_W-1:16];     mac_clr = 1'b0; mac_shift = 1'b1; end
            3'd6: begin mac_a = a_q;   mac_b = {1'b0, r_prn[15:0]};  mac_clr = 1'b1; mac_shift = 1'b0; end
            3'd7: begin mac_a = a_q;   mac_b = r_prn[PR_W-1:16];     mac_clr = 1'b0; mac_shift = 1'b1; end
        endcase
    end

    assign mac_prod = {{(PROB_W+1){1'b0}}, mac_a} * {{(PROB_W+1){1'b0}}, mac_b};
    assign mac_add  = mac_shift ? ACC_W'({mac_prod, 16'b0}) : ACC_W'(mac_prod);
    assign mac_sum  = (mac_clr ? '0 : r_acc) + mac_add;

    // Divider setup: numerator is p'*65536 plus half the divisor for rounding.
    assign ps  = r_p[ACC_W-1:16];
    assign qs  = r_acc[ACC_W-1:16];
    assign sum = {1'b0, ps} + {1'b0, qs};
    assign num = {1'b0, ps, 16'b0} + NUM_W'(sum >> 1);

    // One restoring division step.
    assign trial    = {r_rem[REM_W-2:0], r_num_lo[QUO_W-1]};
    assign trial_ge = trial >= {1'b0, r_sum};

    // Saturated quotient and write-back of the updated cell.
    assign new_prob      = r_quo[QUO_W-1] ? PROB_MAX : r_quo[PROB_W-1:0];
    assign ram_we        = (r_state == S_WB);
    assign ram_wr.cls    = r_new_cls;
    assign ram_wr.prob   = new_prob;

    // The result register takes a new word once it is free or being emptied.
    assign out_load = (r_state == S_OUT) && (!r_out_valid || o_rsp.ready);

    // Sequencer with result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_vld       <= '0;
            r_out_valid <= 1'b0;
            r_step      <= 3'd0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_req_type <= i_req.req_type;
                        r_idx      <= IDX_W'(int'(i_req.cell_row) * GRID_SIZE
                                             + int'(i_req.cell_col));
                        r_sx       <= i_req.slope_x;
                        r_sy       <= i_req.slope_y;
                        r_cnt      <= i_req.point_count;
                        r_state    <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    // A cell never written reads as 0.5 and unobserved.
                    r_prob <= r_vld[r_idx] ? ram_rd.prob : PROB_HALF;
                    r_cls  <= r_vld[r_idx] ? ram_rd.cls  : CLS_UNOBS;
                    r_flat <= (mag_x <= {1'b0, r_slope_limit})
                              && (mag_y <= {1'b0, r_slope_limit});
                    r_step <= 3'd0;
                    r_upd  <= 1'b0;
                    r_state <= do_update ? S_MAC : S_OUT;
                end
                S_MAC: begin
                    r_acc  <= mac_sum;
                    r_step <= r_step + 3'd1;
                    unique case (r_step)
                        3'd1:    r_prt <= mac_sum[PR_W-1:0];
                        3'd3:    r_prn <= mac_sum[PR_W-1:0];
                        3'd5:    r_p   <= mac_sum;
                        default: ;
                    endcase
                    if (r_step == 3'd7) begin
                        r_state <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    r_sum     <= sum;
                    r_rem     <= REM_W'(num >> QUO_W);
                    r_num_lo  <= num[QUO_W-1:0];
                    r_quo     <= '0;
                    r_bit     <= DIV_LAST_BIT;
                    r_new_cls <= (r_p > r_acc) ? CLS_TRAV : CLS_STEEP;
                    // No evidence at all leaves the cell as it is.
                    r_state   <= (sum == '0) ? S_OUT : S_DIV;
                end
                S_DIV: begin
                    r_rem    <= trial_ge ? (trial - {1'b0, r_sum}) : trial;
                    r_num_lo <= {r_num_lo[QUO_W-2:0], 1'b0};
                    r_quo    <= {r_quo[QUO_W-2:0], trial_ge};
                    r_bit    <= r_bit - 5'd1;
                    if (r_bit == 5'd0) begin
                        r_state <= S_WB;
                    end
                end
                S_WB: begin
                    r_vld[r_idx] <= 1'b1;
                    r_prob       <= new_prob;
                    r_cls        <= r_new_cls;
                    r_upd        <= 1'b1;
                    r_state      <= S_OUT;
                end
                S_OUT: begin
                    // Wait for the result register to be free.
                    if (out_load) begin
                        r_out_cls   <= r_cls;
                        r_out_prob  <= r_prob;
                        r_out_upd   <= r_upd;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Handshake and result outputs.
    assign i_req.ready      = (r_state == S_IDLE);
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.cell_class = r_out_cls;
    assign o_rsp.trav_prob  = r_out_prob;
    assign o_rsp.updated    = r_out_upd;

    // The remainder stays below the divisor through the division.
    a_rem_below_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < {1'b0, r_sum}))
        else $error("division remainder reached the divisor");

    // The rounded quotient never exceeds 1.0.
    a_quo_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WB) |-> (r_quo <= QUO_W'(ONE_Q16)))
        else $error("quotient above 1.0");

    // An updated cell always carries an observed class.
    a_upd_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.updated) |-> (o_rsp.cell_class != CLS_UNOBS))
        else $error("updated cell reported as unobserved");

    // Class and probability agree for a fresh update.
    a_trav_prob: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.updated && o_rsp.cell_class == CLS_TRAV)
        |-> (o_rsp.trav_prob >= PROB_HALF))
        else $error("traversable cell below one half");

    a_steep_prob: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.updated && o_rsp.cell_class == CLS_STEEP)
        |-> (o_rsp.trav_prob <= PROB_HALF))
        else $error("steep cell above one half");

    // An accepted word always starts with the cell read.
    a_accept_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (r_state == S_RD))
        else $error("accepted word did not start a cell read");

endmodule

// ===== tb/grid_cell_traversability_bayes_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Traversability map testbench
// Drives update and read words into the per-cell Bayes filter with random
// gaps on both channels and reprograms its registers between phases. Each
// accepted word is run through a local copy of the cell map, and every
// report word is checked field by field against that prediction.
// ----------------------------------------------------------------------------
module grid_cell_traversability_bayes_top_test;
    import gctb_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_WORDS   = 75;
    localparam int GAP_PERCENT   = 17;
    localparam int MAX_PRINTED   = 40;

    // One request word and the report it should produce.
    typedef struct {
        logic                      req_type;
        logic [COORD_W-1:0]        cell_row;
        logic [COORD_W-1:0]        cell_col;
        logic signed [SLOPE_W-1:0] slope_x;
        logic signed [SLOPE_W-1:0] slope_y;
        logic [COUNT_W-1:0]        point_count;
    } t_cell_req;

    typedef struct {
        t_cell_class       cls;
        logic [PROB_W-1:0] prob;
        logic              updated;
    } t_cell_report;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             cfg_we;
    t_cfg_idx         cfg_idx;
    logic [CFG_W-1:0] cfg_data;

    gctb_req_if req_ch ();
    gctb_rsp_if rsp_ch ();

    grid_cell_traversability_bayes_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Words waiting for the driver and reports waiting for the monitor.
    t_cell_req    cell_requests[$];
    t_cell_report cell_reports[$];
    t_cell_req    word_on_bus;

    // Local copy of the map and of the registers.
    logic [PROB_W-1:0]  map_prob  [CELLS];
    t_cell_class        map_class [CELLS];
    logic [LIMIT_W-1:0] lim_slope;
    logic [PROB_W-1:0]  trust_q16;
    logic [PROB_W-1:0]  stay_q16;
    logic [COUNT_W-1:0] min_pts;

    int error_count = 0;
    int cycle_count = 0;
    bit no_gaps     = 1'b0;

    // Clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hard stop in case the block hangs.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic report_mismatch(string msg);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("[%0t] %s", $time, msg);
    endtask

    function automatic bit take_gap();
        return !no_gaps && ($urandom_range(99) < GAP_PERCENT);
    endfunction

    function automatic void reset_map();
        for (int i = 0; i < CELLS; i++) begin
            map_prob[i]  = PROB_HALF;
            map_class[i] = CLS_UNOBS;
        end
        lim_slope = SLOPE_LIMIT_RST;
        trust_q16 = SENSOR_TRUST_RST;
        stay_q16  = STAY_PROB_RST;
        min_pts   = MIN_POINTS_RST;
    endfunction

    // Bayes step for one word: Markov prediction, sensor likelihood and the
    // normalizing division, applied to the local map.
    function automatic t_cell_report filter_cell(t_cell_req w);
        t_cell_report      r;
        int unsigned       idx;
        int                mag_x, mag_y;
        bit                flat;
        longint unsigned   cur, cur_n, s, sn, t, tn, pr_t, pr_n, p, q, ps, qs, sum, np;
        r.updated = 1'b0;
        // A cell outside the grid reports the reset state.
        if (w.cell_row >= GRID_SIZE || w.cell_col >= GRID_SIZE) begin
            r.cls  = CLS_UNOBS;
            r.prob = PROB_HALF;
            return r;
        end
        idx = w.cell_row * GRID_SIZE + w.cell_col;
        if (w.req_type == REQ_UPDATE && w.point_count >= min_pts) begin
            mag_x = (w.slope_x < 0) ? -int'(w.slope_x) : int'(w.slope_x);
            mag_y = (w.slope_y < 0) ? -int'(w.slope_y) : int'(w.slope_y);
            flat  = (mag_x <= int'(lim_slope)) && (mag_y <= int'(lim_slope));
            cur   = map_prob[idx];
            cur_n = ONE_Q16 - cur;
            s     = stay_q16;
            sn    = ONE_Q16 - stay_q16;
            t     = trust_q16;
            tn    = ONE_Q16 - trust_q16;
            pr_t  = s * cur + sn * cur_n;
            pr_n  = sn * cur + s * cur_n;
            p     = (flat ? t : tn) * pr_t;
            q     = (flat ? tn : t) * pr_n;
            ps    = p >> 16;
            qs    = q >> 16;
            sum   = ps + qs;
            // With no evidence at all the cell is left as it was.
            if (sum != 0) begin
                np = ((ps << 16) + (sum >> 1)) / sum;
                if (np > PROB_MAX)
                    np = PROB_MAX;
                map_prob[idx]  = np[PROB_W-1:0];
                map_class[idx] = (p > q) ? CLS_TRAV : CLS_STEEP;
                r.updated      = 1'b1;
            end
        end
        r.cls  = map_class[idx];
        r.prob = map_prob[idx];
        return r;
    endfunction

    // Driver: holds a word until it is taken, then maybe idles.
    always @(posedge i_clk) begin : driver
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            if (req_ch.valid && req_ch.ready)
                cell_reports.insert(cell_reports.size(), filter_cell(word_on_bus));
            if (!req_ch.valid || req_ch.ready) begin
                if (cell_requests.size() != 0 && !take_gap()) begin
                    word_on_bus           = cell_requests.pop_front();
                    req_ch.valid         <= 1'b1;
                    req_ch.req_type      <= word_on_bus.req_type;
                    req_ch.cell_row      <= word_on_bus.cell_row;
                    req_ch.cell_col      <= word_on_bus.cell_col;
                    req_ch.slope_x       <= word_on_bus.slope_x;
                    req_ch.slope_y       <= word_on_bus.slope_y;
                    req_ch.point_count   <= word_on_bus.point_count;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each report word against the oldest prediction.
    always @(posedge i_clk) begin : monitor
        t_cell_report want;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (cell_reports.size() == 0) begin
                    report_mismatch($sformatf("report word (class %0d, prob %0d) with none due",
                                              rsp_ch.cell_class, rsp_ch.trav_prob));
                end else begin
                    want = cell_reports.pop_front();
                    if (rsp_ch.cell_class !== want.cls)
                        report_mismatch($sformatf("cell_class %0d, expected %0d",
                                                  rsp_ch.cell_class, want.cls));
                    if (rsp_ch.trav_prob !== want.prob)
                        report_mismatch($sformatf("trav_prob %0d, expected %0d",
                                                  rsp_ch.trav_prob, want.prob));
                    if (rsp_ch.updated !== want.updated)
                        report_mismatch($sformatf("updated %0d, expected %0d",
                                                  rsp_ch.updated, want.updated));
                end
            end
            rsp_ch.ready <= !take_gap();
        end
    end

    // Register write; the local copy follows with the same masking.
    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] value);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_SLOPE_LIMIT:  lim_slope = value[LIMIT_W-1:0];
            CFG_SENSOR_TRUST: trust_q16 = value;
            CFG_STAY_PROB:    stay_q16  = value;
            CFG_MIN_POINTS:   min_pts   = value;
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (cell_requests.size() != 0 || req_ch.valid || cell_reports.size() != 0)
            @(negedge i_clk);
    endtask

    function automatic void add_request(logic rt, int row, int col, int sx, int sy, int cnt);
        t_cell_req w;
        w.req_type    = rt;
        w.cell_row    = COORD_W'(row);
        w.cell_col    = COORD_W'(col);
        w.slope_x     = SLOPE_W'(sx);
        w.slope_y     = SLOPE_W'(sy);
        w.point_count = COUNT_W'(cnt);
        cell_requests.insert(cell_requests.size(), w);
    endfunction

    function automatic logic [CFG_W-1:0] pick_reg_value(logic [CFG_W-1:0] reset_val);
        case ($urandom_range(4))
            0:       return '0;
            1:       return '1;
            2:       return reset_val;
            default: return CFG_W'($urandom);
        endcase
    endfunction

    // Slopes cluster around the flat limit so both outcomes show up often.
    function automatic logic signed [SLOPE_W-1:0] random_slope();
        int lim;
        int m;
        lim = int'(lim_slope);
        case ($urandom_range(3))
            0: return SLOPE_W'($urandom);
            1: return SLOPE_W'(int'($urandom_range(2 * lim)) - lim);
            2: begin
                m = int'($urandom_range(2)) + lim - 1;
                return $urandom_range(1) ? SLOPE_W'(-m) : SLOPE_W'(m);
            end
            default: return SLOPE_W'(int'($urandom_range(64)) - 32);
        endcase
    endfunction

    // Mostly well-formed updates on a few hot cells, plus reads and
    // updates that fall short of the point threshold.
    function automatic t_cell_req random_request();
        t_cell_req w;
        w.req_type = ($urandom_range(99) < 20) ? REQ_READ : REQ_UPDATE;
        if ($urandom_range(1)) begin
            w.cell_row = COORD_W'($urandom_range(3));
            w.cell_col = COORD_W'($urandom_range(3));
        end else begin
            w.cell_row = COORD_W'($urandom);
            w.cell_col = COORD_W'($urandom);
        end
        w.slope_x = random_slope();
        w.slope_y = random_slope();
        case ($urandom_range(9))
            0:       w.point_count = COUNT_W'($urandom);
            1:       w.point_count = (min_pts > 0) ? COUNT_W'($urandom_range(min_pts - 1, 0))
                                                   : '0;
            default: w.point_count = COUNT_W'($urandom_range(16'hFFFF, min_pts));
        endcase
        return w;
    endfunction

    initial begin : stimulus
        int ph;
        i_rst_n              = 1'b0;
        cfg_we               = 1'b0;
        cfg_idx              = CFG_SLOPE_LIMIT;
        cfg_data             = '0;
        req_ch.valid         = 1'b0;
        req_ch.req_type      = REQ_READ;
        req_ch.cell_row      = '0;
        req_ch.cell_col      = '0;
        req_ch.slope_x       = '0;
        req_ch.slope_y       = '0;
        req_ch.point_count   = '0;
        rsp_ch.ready         = 1'b0;
        reset_map();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: boundaries of the flat test and of the point count.
        add_request(REQ_READ,   0,  0,      0,      0,     0);
        add_request(REQ_UPDATE, 0,  0,      0,      0,  1000);
        add_request(REQ_UPDATE, 0,  0,      0,      0,   999);
        add_request(REQ_UPDATE, 15, 15,  2048,  -2048, 65535);
        add_request(REQ_UPDATE, 15, 15,  2049,      0,  5000);
        add_request(REQ_UPDATE, 0,  15,     0,  -2049,  1000);
        add_request(REQ_UPDATE, 15, 0, -32768,  32767,  1000);
        add_request(REQ_UPDATE, 15, 0,  32767, -32768,     0);
        add_request(REQ_READ,   15, 15,     0,      0,     0);
        add_request(REQ_READ,   15, 0,      0,      0,     0);
        add_request(REQ_READ,   0,  15,    -1,     -1, 65535);
        add_request(REQ_UPDATE, 7,  9,     -1,      1,  1000);
        add_request(REQ_UPDATE, 7,  9,     -1,      1,  1000);
        add_request(REQ_READ,   7,  9,      0,      0,     0);
        wait_drained();

        // Zero trust drives one cell to 0.0 and saturates another at the top;
        // the slope limit write checks masking to 15 bits.
        write_reg(CFG_SENSOR_TRUST, '0);
        write_reg(CFG_STAY_PROB,    '1);
        write_reg(CFG_SLOPE_LIMIT,  '1);
        write_reg(CFG_MIN_POINTS,   '0);
        add_request(REQ_UPDATE, 3, 4,      0, 0, 0);
        add_request(REQ_UPDATE, 5, 5, -32768, 0, 0);
        add_request(REQ_READ,   3, 4,      0, 0, 0);
        wait_drained();

        // With no stay probability either, the cell at 0.0 has no evidence.
        write_reg(CFG_STAY_PROB, '0);
        add_request(REQ_UPDATE, 3, 4, 0, 0, 0);
        add_request(REQ_READ,   3, 4, 0, 0, 0);
        wait_drained();

        // Zero slope limit and the largest point threshold.
        write_reg(CFG_SLOPE_LIMIT,  '0);
        write_reg(CFG_MIN_POINTS,   '1);
        write_reg(CFG_SENSOR_TRUST, '1);
        write_reg(CFG_STAY_PROB,    PROB_HALF);
        add_request(REQ_UPDATE, 1, 1, 0, 0, 65535);
        add_request(REQ_UPDATE, 1, 2, 1, 0, 65535);
        add_request(REQ_UPDATE, 1, 1, 0, 0, 65534);
        wait_drained();

        // Random phases, each under its own register setting.
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            write_reg(CFG_SLOPE_LIMIT,  pick_reg_value(CFG_W'(SLOPE_LIMIT_RST)));
            write_reg(CFG_SENSOR_TRUST, pick_reg_value(SENSOR_TRUST_RST));
            write_reg(CFG_STAY_PROB,    pick_reg_value(STAY_PROB_RST));
            write_reg(CFG_MIN_POINTS,   pick_reg_value(MIN_POINTS_RST));
            no_gaps = (ph == 3);
            repeat (PHASE_WORDS) cell_requests.insert(cell_requests.size(), random_request());
            wait_drained();
        end
        no_gaps = 1'b0;

        // Let any stray report word show up before the verdict.
        repeat (40) @(posedge i_clk);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
